// ===== sv/mhpq_pkg.sv =====
package mhpq_pkg;

   localparam int PRI_W      = 32;
   localparam int TAG_W      = 16;
   localparam int CNT_W      = 9;
   localparam int STAT_W     = 2;
   localparam int REQ_DATA_W = 48;
   localparam int RSP_DATA_W = 64;
   localparam int RSP_PAD_W  = RSP_DATA_W - PRI_W - TAG_W - CNT_W;

   typedef logic [STAT_W-1:0] status_type;

   localparam status_type ST_OK    = 2'd0;
   localparam status_type ST_EMPTY = 2'd1;
   localparam status_type ST_FULL  = 2'd2;

   localparam logic OP_INSERT  = 1'b0;
   localparam logic OP_EXTRACT = 1'b1;

   // controller -> datapath
   typedef struct packed {
      logic capture;    // latch request, clear result
      logic ins_begin;  // open hole at the end, read its parent
      logic up_step;    // move parent down into hole
      logic place;      // write held entry into hole
      logic ext_begin;  // read root and last entry
      logic ext_load;   // take root as result, last entry into hand
      logic down_step;  // move smaller child up into hole
      logic set_full;
      logic set_empty;
      logic rsp_load;
   } cmd_type;

   // datapath -> controller
   typedef struct packed {
      logic full;
      logic empty;
      logic last;
      logic up_move;
      logic par_root;
      logic down_move;
   } flag_type;

endpackage

// ===== sv/mhpq_ctrl.sv =====
module mhpq_ctrl
   import mhpq_pkg::*;
(
   input  logic     clock,
   input  logic     reset,
   input  logic     req_tvalid,
   output logic     req_tready,
   input  logic     req_op,
   output logic     rsp_tvalid,
   input  logic     rsp_tready,
   input  flag_type flags,
   output cmd_type  cmd
);

   localparam logic [2:0] S_IDLE  = 3'd0;
   localparam logic [2:0] S_INS   = 3'd1;
   localparam logic [2:0] S_UP    = 3'd2;
   localparam logic [2:0] S_PLACE = 3'd3;
   localparam logic [2:0] S_EXT   = 3'd4;
   localparam logic [2:0] S_EXLD  = 3'd5;
   localparam logic [2:0] S_DOWN  = 3'd6;
   localparam logic [2:0] S_DONE  = 3'd7;

   logic [2:0] state_ff, state_in;
   logic       rsp_valid_ff, rsp_valid_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign req_tready = (state_ff == S_IDLE);
   assign rsp_tvalid = rsp_valid_ff;

   always_comb begin
      cmd          = '0;
      state_in     = state_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_tready;
      unique case (state_ff)
         S_IDLE: begin
            if (req_tvalid) begin
               cmd.capture = 1'b1;
               state_in    = (req_op == OP_EXTRACT) ? S_EXT : S_INS;
            end
         end
         S_INS: begin
            if (flags.full) begin
               cmd.set_full = 1'b1;
               state_in     = S_DONE;
            end else begin
               cmd.ins_begin = 1'b1;
               state_in      = flags.empty ? S_PLACE : S_UP;
            end
         end
         S_UP: begin
            if (flags.up_move) begin
               cmd.up_step = 1'b1;
               state_in    = flags.par_root ? S_PLACE : S_UP;
            end else begin
               cmd.place = 1'b1;
               state_in  = S_DONE;
            end
         end
         S_PLACE: begin
            cmd.place = 1'b1;
            state_in  = S_DONE;
         end
         S_EXT: begin
            if (flags.empty) begin
               cmd.set_empty = 1'b1;
               state_in      = S_DONE;
            end else begin
               cmd.ext_begin = 1'b1;
               state_in      = S_EXLD;
            end
         end
         S_EXLD: begin
            cmd.ext_load = 1'b1;
            state_in     = flags.last ? S_DONE : S_DOWN;
         end
         S_DOWN: begin
            if (flags.down_move) begin
               cmd.down_step = 1'b1;
            end else begin
               cmd.place = 1'b1;
               state_in  = S_DONE;
            end
         end
         S_DONE: begin
            if (!rsp_valid_ff || rsp_tready) begin
               cmd.rsp_load = 1'b1;
               rsp_valid_in = 1'b1;
               state_in     = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

endmodule

// ===== sv/mhpq_dpath.sv =====
module mhpq_dpath
   import mhpq_pkg::*;
#(
   parameter int HEAP_DEPTH = 256,
   parameter int KEY_BITS   = 32,
   parameter int TAG_BITS   = 16
)(
   input  logic             clock,
   input  logic             reset,
   input  cmd_type          cmd,
   output flag_type         flags,
   input  logic [PRI_W-1:0] req_priority,
   input  logic [TAG_W-1:0] req_tag,
   output logic [PRI_W-1:0] rsp_priority,
   output logic [TAG_W-1:0] rsp_tag,
   output status_type       rsp_status,
   output logic [CNT_W-1:0] rsp_count
);

   localparam int AW = (HEAP_DEPTH > 1) ? $clog2(HEAP_DEPTH) : 1;
   localparam int CW = $clog2(HEAP_DEPTH + 1);
   localparam int IW = AW + 2;
   localparam int EW = KEY_BITS + TAG_BITS;

   logic [EW-1:0]       mem [HEAP_DEPTH];
   logic [EW-1:0]       rd_a_ff, rd_b_ff;
   logic [AW-1:0]       rd_a_addr, rd_b_addr, wr_addr;
   logic [EW-1:0]       wr_data;
   logic                wr_en;

   logic [KEY_BITS-1:0] cur_key_ff, cur_key_in;
   logic [TAG_BITS-1:0] cur_tag_ff, cur_tag_in;
   logic [KEY_BITS-1:0] res_key_ff, res_key_in;
   logic [TAG_BITS-1:0] res_tag_ff, res_tag_in;
   status_type          status_ff, status_in;
   logic [AW-1:0]       pos_ff, pos_in;
   logic [CW-1:0]       count_ff, count_in;

   logic [PRI_W-1:0]    out_pri_ff;
   logic [TAG_W-1:0]    out_tag_ff;
   status_type          out_stat_ff;
   logic [CNT_W-1:0]    out_cnt_ff;

   logic [AW-1:0]       par_idx, gpar_idx, end_par;
   logic [IW-1:0]       lc, rc, sel_idx, lc2, rc2;
   logic [KEY_BITS-1:0] lkey, rkey, ckey;
   logic                lv, rv, pick_right;

   assign par_idx  = (pos_ff - AW'(1)) >> 1;
   assign gpar_idx = (par_idx - AW'(1)) >> 1;
   assign end_par  = (AW'(count_ff) - AW'(1)) >> 1;

   assign lc  = (IW'(pos_ff) << 1) + IW'(1);
   assign rc  = lc + IW'(1);
   assign lv  = lc < IW'(count_ff);
   assign rv  = rc < IW'(count_ff);

   assign lkey       = rd_a_ff[KEY_BITS-1:0];
   assign rkey       = rd_b_ff[KEY_BITS-1:0];
   assign pick_right = rv && (rkey < lkey);
   assign ckey       = pick_right ? rkey : lkey;
   assign sel_idx    = pick_right ? rc : lc;
   assign lc2        = (sel_idx << 1) + IW'(1);
   assign rc2        = lc2 + IW'(1);

   always_comb begin
      flags.full      = (count_ff == CW'(HEAP_DEPTH));
      flags.empty     = (count_ff == '0);
      flags.last      = (count_ff == CW'(1));
      flags.up_move   = (lkey > cur_key_ff);
      flags.par_root  = (par_idx == '0);
      flags.down_move = lv && (ckey < cur_key_ff);
   end

   always_comb begin
      rd_a_addr  = '0;
      rd_b_addr  = '0;
      wr_en      = 1'b0;
      wr_addr    = pos_ff;
      wr_data    = {cur_tag_ff, cur_key_ff};
      cur_key_in = cur_key_ff;
      cur_tag_in = cur_tag_ff;
      res_key_in = res_key_ff;
      res_tag_in = res_tag_ff;
      status_in  = status_ff;
      pos_in     = pos_ff;
      count_in   = count_ff;
      if (cmd.capture) begin
         cur_key_in = KEY_BITS'(req_priority);
         cur_tag_in = TAG_BITS'(req_tag);
         res_key_in = '0;
         res_tag_in = '0;
         status_in  = ST_OK;
      end
      if (cmd.set_full)  status_in = ST_FULL;
      if (cmd.set_empty) status_in = ST_EMPTY;
      if (cmd.ins_begin) begin
         pos_in    = AW'(count_ff);
         count_in  = count_ff + CW'(1);
         rd_a_addr = end_par;
      end
      if (cmd.up_step) begin
         wr_en     = 1'b1;
         wr_data   = rd_a_ff;
         pos_in    = par_idx;
         rd_a_addr = gpar_idx;
      end
      if (cmd.place) begin
         wr_en = 1'b1;
      end
      if (cmd.ext_begin) begin
         rd_a_addr = '0;
         rd_b_addr = AW'(count_ff - CW'(1));
      end
      if (cmd.ext_load) begin
         res_key_in = rd_a_ff[KEY_BITS-1:0];
         res_tag_in = rd_a_ff[EW-1:KEY_BITS];
         cur_key_in = rd_b_ff[KEY_BITS-1:0];
         cur_tag_in = rd_b_ff[EW-1:KEY_BITS];
         count_in   = count_ff - CW'(1);
         pos_in     = '0;
         rd_a_addr  = AW'(1);
         rd_b_addr  = AW'(2);
      end
      if (cmd.down_step) begin
         wr_en     = 1'b1;
         wr_data   = pick_right ? rd_b_ff : rd_a_ff;
         pos_in    = AW'(sel_idx);
         rd_a_addr = AW'(lc2);
         rd_b_addr = AW'(rc2);
      end
   end

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_a_ff <= mem[rd_a_addr];
      rd_b_ff <= mem[rd_b_addr];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= '0;
      end else begin
         count_ff <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      cur_key_ff <= cur_key_in;
      cur_tag_ff <= cur_tag_in;
      res_key_ff <= res_key_in;
      res_tag_ff <= res_tag_in;
      status_ff  <= status_in;
      pos_ff     <= pos_in;
      if (cmd.rsp_load) begin
         out_pri_ff  <= PRI_W'(res_key_ff);
         out_tag_ff  <= TAG_W'(res_tag_ff);
         out_stat_ff <= status_ff;
         out_cnt_ff  <= CNT_W'(count_ff);
      end
   end

   assign rsp_priority = out_pri_ff;
   assign rsp_tag      = out_tag_ff;
   assign rsp_status   = out_stat_ff;
   assign rsp_count    = out_cnt_ff;

endmodule

// ===== sv/min_heap_priority_queue.sv =====
// Binary min-heap priority queue.
// Request channel (req_*): tuser[0] is the operation (0 insert, 1 extract
// minimum); tdata carries the key and tag used by an insert.
// Response channel (rsp_*): one transaction per request, in order, with the
// extracted key and tag (zero for inserts and failures), a status in tuser
// (ok, extract from empty heap, insert into full heap) and the entry count
// after the operation.
// A rejected insert or an extract from the empty heap goes straight to the
// response; any other insert or extract walks the heap, one tree level per
// cycle, through a memory with one write port and two registered read ports.
// One request is in work at a time, so a new request is not taken until the
// previous one has finished and loaded its response.
// A request is accepted in the cycle after the previous response is loaded,
// even while that response still waits in the output register.
// When the receiver stalls, the response holds and a finished request waits
// until the output register frees. Reset empties the heap; memory contents
// are not cleared.
module min_heap_priority_queue
   import mhpq_pkg::*;
#(
   parameter int HEAP_DEPTH = 256,
   parameter int KEY_BITS   = 32,
   parameter int TAG_BITS   = 16
)(
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_tvalid,
   output logic                  req_tready,
   input  logic [REQ_DATA_W-1:0] req_tdata,  // priority_req[31:0], tag[47:32]
   input  logic [0:0]            req_tuser,  // op[0]
   output logic                  rsp_tvalid,
   input  logic                  rsp_tready,
   // out_priority[31:0], out_tag[47:32], count_after[56:48], zero[63:57]
   output logic [RSP_DATA_W-1:0] rsp_tdata,
   output logic [STAT_W-1:0]     rsp_tuser   // status[1:0]
);

   cmd_type          cmd;
   flag_type         flags;
   logic [PRI_W-1:0] rsp_priority;
   logic [TAG_W-1:0] rsp_tag;
   status_type       rsp_status;
   logic [CNT_W-1:0] rsp_count;

   mhpq_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_op     (req_tuser[0]),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .flags      (flags),
      .cmd        (cmd)
   );

   mhpq_dpath #(
      .HEAP_DEPTH (HEAP_DEPTH),
      .KEY_BITS   (KEY_BITS),
      .TAG_BITS   (TAG_BITS)
   ) u_dpath (
      .clock        (clock),
      .reset        (reset),
      .cmd          (cmd),
      .flags        (flags),
      .req_priority (req_tdata[PRI_W-1:0]),
      .req_tag      (req_tdata[PRI_W+TAG_W-1:PRI_W]),
      .rsp_priority (rsp_priority),
      .rsp_tag      (rsp_tag),
      .rsp_status   (rsp_status),
      .rsp_count    (rsp_count)
   );

   assign rsp_tdata = {{RSP_PAD_W{1'b0}}, rsp_count, rsp_tag, rsp_priority};
   assign rsp_tuser = rsp_status;

`ifndef SYNTH
   a_wr_onehot: assert property (@(posedge clock) disable iff (reset)
      $onehot0({cmd.up_step, cmd.place, cmd.down_step}))
      else $error("more than one heap write command");

   a_full_count: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_status == ST_FULL |-> rsp_count == CNT_W'(HEAP_DEPTH))
      else $error("full status with count below depth");

   a_empty_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_status == ST_EMPTY |->
         rsp_count == '0 && rsp_priority == '0 && rsp_tag == '0)
      else $error("empty status with nonzero fields");

   a_load_free: assert property (@(posedge clock) disable iff (reset)
      cmd.rsp_load |-> !rsp_tvalid || rsp_tready)
      else $error("response overwritten while pending");
`endif

endmodule

// ===== tb/min_heap_priority_queue_test.sv =====
`timescale 1ns / 1ps

module min_heap_priority_queue_test;
   import mhpq_pkg::*;

   localparam int HEAP_SLOTS = 256;
   localparam int NUM_DIRECTED = 23;

   typedef struct packed {
      logic [PRI_W-1:0] pri;
      logic [TAG_W-1:0] tag;
      status_type       status;
      logic [CNT_W-1:0] count;
   } heap_rsp;

   typedef struct packed {
      logic             op;
      logic [PRI_W-1:0] key;
      logic [TAG_W-1:0] tag;
      logic             fixed_rsp;
      heap_rsp          want;
   } heap_req;

   logic                  clock = 1'b0;
   logic                  reset = 1'b1;
   logic                  req_tvalid = 1'b0;
   logic                  req_tready;
   logic [REQ_DATA_W-1:0] req_tdata = '0;  // priority_req[31:0], tag[47:32]
   logic [0:0]            req_tuser = '0;  // op[0]
   logic                  rsp_tvalid;
   logic                  rsp_tready = 1'b0;
   // out_priority[31:0], out_tag[47:32], count_after[56:48], zero[63:57]
   logic [RSP_DATA_W-1:0] rsp_tdata;
   logic [STAT_W-1:0]     rsp_tuser;        // status[1:0]

   logic [PRI_W-1:0] heap_key [HEAP_SLOTS];
   logic [TAG_W-1:0] heap_tag [HEAP_SLOTS];
   int               heap_count = 0;
   heap_rsp          pending_rsp [$];
   int               error_count = 0;
   int               burst_left = 0;
   logic [8:0]       stall_cycle = '0;

   // extremes and error codes typed in, the rest comes from the heap predictor
   localparam heap_req DIRECTED [NUM_DIRECTED] = '{
      '{OP_EXTRACT, 32'h0,        16'h0,    1'b1, '{32'h0, 16'h0, ST_EMPTY, 9'd0}},
      '{OP_INSERT,  32'hFFFFFFFF, 16'hFFFF, 1'b1, '{32'h0, 16'h0, ST_OK, 9'd1}},
      '{OP_EXTRACT, 32'hDEADBEEF, 16'h1234, 1'b1, '{32'hFFFFFFFF, 16'hFFFF, ST_OK, 9'd0}},
      '{OP_EXTRACT, 32'hFFFFFFFF, 16'hFFFF, 1'b1, '{32'h0, 16'h0, ST_EMPTY, 9'd0}},
      '{OP_INSERT,  32'h0,        16'h0,    1'b1, '{32'h0, 16'h0, ST_OK, 9'd1}},
      '{OP_INSERT,  32'h0,        16'h0001, 1'b0, '0},
      '{OP_INSERT,  32'h0,        16'h0002, 1'b0, '0},
      '{OP_INSERT,  32'h5,        16'h0005, 1'b0, '0},
      '{OP_INSERT,  32'h5,        16'h0006, 1'b0, '0},
      '{OP_INSERT,  32'h3,        16'h0007, 1'b0, '0},
      '{OP_INSERT,  32'hFFFFFFFF, 16'hAAAA, 1'b0, '0},
      '{OP_INSERT,  32'h80000000, 16'h5555, 1'b0, '0},
      '{OP_INSERT,  32'h1,        16'h8000, 1'b0, '0},
      '{OP_EXTRACT, 32'h0,        16'h0,    1'b0, '0},
      '{OP_EXTRACT, 32'hFFFFFFFF, 16'hFFFF, 1'b0, '0},
      '{OP_EXTRACT, 32'h0,        16'h0,    1'b0, '0},
      '{OP_EXTRACT, 32'h0,        16'h0,    1'b0, '0},
      '{OP_EXTRACT, 32'h0,        16'h0,    1'b0, '0},
      '{OP_EXTRACT, 32'h0,        16'h0,    1'b0, '0},
      '{OP_EXTRACT, 32'h0,        16'h0,    1'b0, '0},
      '{OP_EXTRACT, 32'h0,        16'h0,    1'b0, '0},
      '{OP_EXTRACT, 32'h0,        16'h0,    1'b0, '0},
      '{OP_EXTRACT, 32'h0,        16'h0,    1'b1, '{32'h0, 16'h0, ST_EMPTY, 9'd0}}
   };

   min_heap_priority_queue #(
      .HEAP_DEPTH(HEAP_SLOTS),
      .KEY_BITS(PRI_W),
      .TAG_BITS(TAG_W)
   ) dut (
      .clock(clock),
      .reset(reset),
      .req_tvalid(req_tvalid),
      .req_tready(req_tready),
      .req_tdata(req_tdata),
      .req_tuser(req_tuser),
      .rsp_tvalid(rsp_tvalid),
      .rsp_tready(rsp_tready),
      .rsp_tdata(rsp_tdata),
      .rsp_tuser(rsp_tuser)
   );

   always begin
      #2 clock = 1'b1;
      #2 clock = 1'b0;
   end

   function automatic void swap_entries(input int a, input int b);
      logic [PRI_W-1:0] k;
      logic [TAG_W-1:0] t;
      k = heap_key[a];
      t = heap_tag[a];
      heap_key[a] = heap_key[b];
      heap_tag[a] = heap_tag[b];
      heap_key[b] = k;
      heap_tag[b] = t;
   endfunction

   function automatic heap_rsp predict_heap_op(input logic op, input logic [PRI_W-1:0] key,
                                               input logic [TAG_W-1:0] tag);
      heap_rsp r;
      int pos;
      int parent;
      int left;
      int right;
      int best;
      r = '0;
      r.status = ST_OK;
      if (op == OP_INSERT) begin
         if (heap_count >= HEAP_SLOTS) begin
            r.status = ST_FULL;
         end else begin
            pos = heap_count;
            heap_key[pos] = key;
            heap_tag[pos] = tag;
            heap_count++;
            while (pos != 0) begin
               parent = (pos - 1) / 2;
               if (heap_key[parent] <= heap_key[pos]) break;
               swap_entries(pos, parent);
               pos = parent;
            end
         end
      end else if (heap_count == 0) begin
         r.status = ST_EMPTY;
      end else begin
         r.pri = heap_key[0];
         r.tag = heap_tag[0];
         heap_count--;
         if (heap_count != 0) begin
            heap_key[0] = heap_key[heap_count];
            heap_tag[0] = heap_tag[heap_count];
            pos = 0;
            forever begin
               left = 2 * pos + 1;
               right = left + 1;
               best = pos;
               if (left < heap_count && heap_key[left] < heap_key[best]) best = left;
               if (right < heap_count && heap_key[right] < heap_key[best]) best = right;
               if (best == pos) break;
               swap_entries(pos, best);
               pos = best;
            end
         end
      end
      r.count = heap_count[CNT_W-1:0];
      return r;
   endfunction

   function automatic heap_req random_req(input logic op);
      heap_req r;
      r = '0;
      r.op = op;
      case ($urandom_range(0, 5))
         0: r.key = $urandom_range(0, 15);
         1: r.key = '0;
         2: r.key = '1;
         default: r.key = $urandom;
      endcase
      r.tag = TAG_W'($urandom_range(0, 65535));
      return r;
   endfunction

   // called at a falling edge; returns at a falling edge
   task automatic push_request(input heap_req r);
      heap_rsp predicted;
      req_tvalid <= 1'b1;
      req_tuser <= r.op;
      req_tdata <= {r.tag, r.key};
      do @(posedge clock); while (!req_tready);
      predicted = predict_heap_op(r.op, r.key, r.tag);
      pending_rsp.push_back(r.fixed_rsp ? r.want : predicted);
      @(negedge clock);
      if (burst_left == 0) begin
         req_tvalid <= 1'b0;
         repeat ($urandom_range(1, 6)) @(negedge clock);
         burst_left = ($urandom_range(0, 4) == 0) ? $urandom_range(30, 60)
                                                 : $urandom_range(0, 10);
      end else begin
         burst_left--;
      end
   endtask

   always @(negedge clock) begin
      stall_cycle <= stall_cycle + 1'b1;
      case (stall_cycle[8:7])
         2'd0: rsp_tready <= 1'b1;
         2'd1: rsp_tready <= ($urandom_range(0, 3) != 0);
         2'd2: rsp_tready <= (stall_cycle[2:0] != 3'b111) && (stall_cycle[2:0] != 3'b011);
         default: rsp_tready <= ($urandom_range(0, 1) != 0);
      endcase
   end

   task automatic check_field(input string name, input logic [31:0] want,
                              input logic [31:0] got);
      if (want !== got) begin
         $error("%s: expected %0h, got %0h", name, want, got);
         error_count++;
      end
   endtask

   always @(posedge clock) begin
      heap_rsp want;
      if (!reset && rsp_tvalid && rsp_tready) begin
         if (pending_rsp.size() == 0) begin
            $error("response transaction with nothing pending: %0h", rsp_tdata);
            error_count++;
         end else begin
            want = pending_rsp.pop_front();
            check_field("out_priority", 32'(want.pri), 32'(rsp_tdata[PRI_W-1:0]));
            check_field("out_tag", 32'(want.tag), 32'(rsp_tdata[PRI_W +: TAG_W]));
            check_field("count_after", 32'(want.count),
                        32'(rsp_tdata[PRI_W+TAG_W +: CNT_W]));
            check_field("pad", 32'd0, 32'(rsp_tdata[RSP_DATA_W-1 -: RSP_PAD_W]));
            check_field("status", 32'(want.status), 32'(rsp_tuser));
         end
      end
   end

   initial begin
      #2_000_000;
      $display("DONE: errors detected");
      $finish;
   end

   initial begin
      int i;
      repeat (9) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      burst_left = $urandom_range(0, 10);

      for (i = 0; i < NUM_DIRECTED; i++) push_request(DIRECTED[i]);

      // mixed traffic around a small heap
      repeat (60) push_request(random_req(1'($urandom_range(0, 1))));
      // fill to capacity, then push against the full heap
      while (heap_count < HEAP_SLOTS)
         push_request(random_req(($urandom_range(0, 19) == 0) ? OP_EXTRACT : OP_INSERT));
      repeat (3) push_request(random_req(OP_INSERT));
      // drain to empty, then extract from the empty heap
      while (heap_count > 0)
         push_request(random_req(($urandom_range(0, 19) == 0) ? OP_INSERT : OP_EXTRACT));
      repeat (3) push_request(random_req(OP_EXTRACT));
      repeat (40) push_request(random_req(1'($urandom_range(0, 1))));

      req_tvalid <= 1'b0;
      while (pending_rsp.size() != 0) @(posedge clock);
      repeat (40) @(posedge clock);
      if (error_count == 0) begin
         $display("DONE: 0 errors");
      end else begin
         $display("DONE: errors detected");
      end
      $finish;
   end

endmodule
